// ----- design/deq_pkg.sv -----
`default_nettype none

package deq_pkg;

    // Default sizing of the ring store
    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths on the stream ports
    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int DIN_W    = 32;
    localparam int DOUT_W   = 32;
    localparam int CNT_F_W  = 9;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ       = 3'd4,
        OP_WRITE      = 3'd5,
        OP_INSERT     = 3'd6,
        OP_ERASE      = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } st_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_INS_SHIFT,
        S_INS_PUT,
        S_ERS_FIRST,
        S_ERS_SHIFT
    } state_t;

endpackage

`default_nettype wire

// ----- design/deq_ram.sv -----
`default_nettype none

// Simple dual-port store: one write port, one registered read port
module deq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/double_ended_queue_engine.sv -----
// Sequence: push, push front, write, insert at the end and any refused word finish in
//   the execute state; pop, pop front and read pass through the read-data state; insert
//   inside the deque shifts entries back from the end to the position; erase pulls later
//   entries forward; a stalled result holds the sequencer until the result slot frees.
// Throughput: one word at a time; the next is taken once the sequencer is back in idle.
// Reset: head and count go to zero, the store itself is not cleared.
`default_nettype none

module double_ended_queue_engine
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // position[7:0], data_in[39:8]
    input  wire logic [OP_W-1:0]     s_tuser,  // opcode[2:0]
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    output      logic [M_DATA_W-1:0] m_tdata   // data_out[31:0], count[40:32],
                                               // status[42:41], zero[47:43]
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PCW = (CW > POS_W) ? CW : POS_W;

    // Ring slot of a logical index; head + index stays below twice the depth
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                           input logic [CW-1:0] lidx);
        logic [CW:0] sum;
        begin
            sum = (CW+1)'(head) + (CW+1)'(lidx);
            if (sum >= (CW+1)'(DEPTH))
            begin
                sum = sum - (CW+1)'(DEPTH);
            end
            return sum[AW-1:0];
        end
    endfunction

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [DATA_WIDTH-1:0]  val_reg, val_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [DATA_WIDTH-1:0]  dout_reg, dout_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [DOUT_W-1:0]      m_data_reg, m_data_next;
    logic [CNT_F_W-1:0]     m_count_reg, m_count_next;
    st_t                    m_status_reg, m_status_next;

    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0]  mem_wdata, mem_rdata;

    logic                   finish, out_free;
    st_t                    fin_status;
    logic [DATA_WIDTH-1:0]  fin_dout;

    logic                   is_full, is_empty, pos_ge_cnt, pos_gt_cnt;
    logic [PCW-1:0]         pos_w, cnt_w;
    logic [CW-1:0]          pos_c;
    logic [AW-1:0]          head_dec, head_inc;

    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Checks and pointer steps
    assign pos_w      = PCW'(pos_reg);
    assign cnt_w      = PCW'(count_reg);
    assign pos_c      = CW'(pos_reg);
    assign is_full    = (count_reg == CW'(DEPTH));
    assign is_empty   = (count_reg == '0);
    assign pos_ge_cnt = (pos_w >= cnt_w);
    assign pos_gt_cnt = (pos_w > cnt_w);
    assign head_dec   = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc   = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign out_free   = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_status_reg, m_count_reg, m_data_reg};

    // Sequencer: next state, store accesses, completion
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        dout_next  = dout_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        finish     = 1'b0;
        fin_status = ST_OK;
        fin_dout   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = op_t'(s_tuser);
                    pos_next   = s_tdata[POS_W-1:0];
                    val_next   = DATA_WIDTH'(s_tdata[POS_W +: DIN_W]);
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (op_reg)
                    OP_PUSH_BACK:
                    begin
                        finish = 1'b1;
                        if (is_full)
                        begin
                            fin_status = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = slot(head_reg, count_reg);
                            mem_wdata  = val_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_PUSH_FRONT:
                    begin
                        finish = 1'b1;
                        if (is_full)
                        begin
                            fin_status = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = head_dec;
                            mem_wdata  = val_reg;
                            head_next  = head_dec;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_EMPTY;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = slot(head_reg, count_reg - CW'(1));
                            state_next = S_RDATA;
                        end
                    end
                    OP_POP_FRONT:
                    begin
                        if (is_empty)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_EMPTY;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = head_reg;
                            state_next = S_RDATA;
                        end
                    end
                    OP_READ:
                    begin
                        if (pos_ge_cnt)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_RANGE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = slot(head_reg, pos_c);
                            state_next = S_RDATA;
                        end
                    end
                    OP_WRITE:
                    begin
                        finish = 1'b1;
                        if (pos_ge_cnt)
                        begin
                            fin_status = ST_RANGE;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = slot(head_reg, pos_c);
                            mem_wdata = val_reg;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (is_full)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_FULL;
                        end
                        else if (pos_gt_cnt)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_RANGE;
                        end
                        else if (pos_w == cnt_w)
                        begin
                            // Insert at the end is a plain append
                            finish     = 1'b1;
                            mem_we     = 1'b1;
                            mem_waddr  = slot(head_reg, count_reg);
                            mem_wdata  = val_reg;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            mem_re     = 1'b1;
                            mem_raddr  = slot(head_reg, count_reg - CW'(1));
                            state_next = S_INS_SHIFT;
                        end
                    end
                    OP_ERASE:
                    begin
                        if (is_empty)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_EMPTY;
                        end
                        else if (pos_ge_cnt)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_RANGE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = slot(head_reg, pos_c);
                            state_next = S_ERS_FIRST;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end

            // Read data back: pops and indexed read
            S_RDATA:
            begin
                finish   = 1'b1;
                fin_dout = mem_rdata;
                case (op_reg)
                    OP_POP_BACK:
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    OP_POP_FRONT:
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Move entries one place back, from the end towards the position
            S_INS_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot(head_reg, idx_reg);
                mem_wdata = mem_rdata;
                idx_next  = idx_reg - CW'(1);
                if ((idx_reg - CW'(1)) > pos_c)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = slot(head_reg, idx_reg - CW'(2));
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end

            S_INS_PUT:
            begin
                finish     = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = slot(head_reg, pos_c);
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
            end

            // Capture the erased entry; pull later entries forward if any, else finish
            S_ERS_FIRST:
            begin
                dout_next = mem_rdata;
                if ((PCW+1)'(pos_w) + (PCW+1)'(1) < (PCW+1)'(cnt_w))
                begin
                    idx_next   = pos_c;
                    mem_re     = 1'b1;
                    mem_raddr  = slot(head_reg, pos_c + CW'(1));
                    state_next = S_ERS_SHIFT;
                end
                else
                begin
                    finish     = 1'b1;
                    fin_dout   = mem_rdata;
                    count_next = count_reg - CW'(1);
                end
            end

            S_ERS_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot(head_reg, idx_reg);
                mem_wdata = mem_rdata;
                idx_next  = idx_reg + CW'(1);
                if ((CW+1)'(idx_reg) + (CW+1)'(2) < (CW+1)'(count_reg))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = slot(head_reg, idx_reg + CW'(2));
                end
                else
                begin
                    finish     = 1'b1;
                    fin_dout   = dout_reg;
                    count_next = count_reg - CW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = S_IDLE;
        end

        // Result slot still taken: hold everything, retry next cycle
        if (finish && !out_free)
        begin
            state_next = state_reg;
            head_next  = head_reg;
            count_next = count_reg;
            idx_next   = idx_reg;
            dout_next  = dout_reg;
            mem_we     = 1'b0;
            mem_re     = 1'b0;
        end
    end

    // Output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        m_count_next  = m_count_reg;
        m_status_next = m_status_reg;
        if (finish && out_free)
        begin
            m_tvalid_next = 1'b1;
            m_data_next   = DOUT_W'(fin_dout);
            m_count_next  = CNT_F_W'(count_next);
            m_status_next = fin_status;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        dout_reg     <= dout_next;
        m_data_reg   <= m_data_next;
        m_count_reg  <= m_count_next;
        m_status_reg <= m_status_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re && (mem_waddr == mem_raddr)))
        else $error("store read and write at the same entry");

    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (m_status_reg == ST_EMPTY)) |-> (m_count_reg == '0))
        else $error("empty status with nonzero count");

    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (m_status_reg == ST_FULL)) |-> (m_count_reg == CNT_F_W'(DEPTH)))
        else $error("full status with count below depth");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && !out_free) |=> ($stable(count_reg) && $stable(head_reg)))
        else $error("pointers moved while result was stalled");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top
    import deq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SIZE   = 256;
    localparam int WORD_TARGET = 1750;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int TAIL_CYCLES = 300;
    localparam int PRINT_CAP   = 40;

    // Stimulus mood for a stretch of random words
    typedef enum int {
        BIAS_GROW,
        BIAS_SHRINK,
        BIAS_MIXED
    } bias_t;

    // One expected result word
    typedef struct {
        logic [DOUT_W-1:0]  data;
        logic [CNT_F_W-1:0] fill;
        st_t                status;
    } deq_result_t;

    // Deque predictor plus queue of results still owed by the block
    class deq_scoreboard;
        logic [DOUT_W-1:0] ring [RING_SIZE];
        logic [7:0]        head;
        int                fill;
        deq_result_t       awaited [$];
        int                errors;

        function new();
            head   = '0;
            fill   = 0;
            errors = 0;
        endfunction

        function logic [7:0] slot(int logical);
            return head + logical[7:0];
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Apply one accepted word to the model and queue its result
        function void note_word(op_t op, logic [POS_W-1:0] pos, logic [DIN_W-1:0] din);
            deq_result_t res;
            int          i;
            res.data   = '0;
            res.status = ST_OK;
            case (op)
                OP_PUSH_BACK:
                    if (fill >= RING_SIZE)
                        res.status = ST_FULL;
                    else
                    begin
                        ring[slot(fill)] = din;
                        fill++;
                    end
                OP_PUSH_FRONT:
                    if (fill >= RING_SIZE)
                        res.status = ST_FULL;
                    else
                    begin
                        head = head - 8'd1;
                        ring[head] = din;
                        fill++;
                    end
                OP_POP_BACK:
                    if (fill == 0)
                        res.status = ST_EMPTY;
                    else
                    begin
                        fill--;
                        res.data = ring[slot(fill)];
                    end
                OP_POP_FRONT:
                    if (fill == 0)
                        res.status = ST_EMPTY;
                    else
                    begin
                        res.data = ring[head];
                        head = head + 8'd1;
                        fill--;
                    end
                OP_READ:
                    if (int'(pos) >= fill)
                        res.status = ST_RANGE;
                    else
                        res.data = ring[slot(int'(pos))];
                OP_WRITE:
                    if (int'(pos) >= fill)
                        res.status = ST_RANGE;
                    else
                        ring[slot(int'(pos))] = din;
                OP_INSERT:
                    if (fill >= RING_SIZE)
                        res.status = ST_FULL;
                    else if (int'(pos) > fill)
                        res.status = ST_RANGE;
                    else
                    begin
                        // later entries move one place back
                        for (i = fill; i > int'(pos); i--)
                            ring[slot(i)] = ring[slot(i - 1)];
                        ring[slot(int'(pos))] = din;
                        fill++;
                    end
                default:
                    if (fill == 0)
                        res.status = ST_EMPTY;
                    else if (int'(pos) >= fill)
                        res.status = ST_RANGE;
                    else
                    begin
                        // later entries move one place forward
                        res.data = ring[slot(int'(pos))];
                        for (i = int'(pos); i + 1 < fill; i++)
                            ring[slot(i)] = ring[slot(i + 1)];
                        fill--;
                    end
            endcase
            res.fill = fill[CNT_F_W-1:0];
            awaited.insert(awaited.size(), res);
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one accepted result word with the oldest expectation
        task check_word(logic [M_DATA_W-1:0] word);
            deq_result_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result word %h", word));
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            if (word[31:0] !== want.data)
                report($sformatf("data_out %h, want %h", word[31:0], want.data));
            if (word[40:32] !== want.fill)
                report($sformatf("count %0d, want %0d", word[40:32], want.fill));
            if (word[42:41] !== want.status)
                report($sformatf("status %0d, want %0d", word[42:41], want.status));
        endtask
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // position[7:0], data_in[39:8]
    logic [OP_W-1:0]     s_tuser  = '0;   // opcode[2:0]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // data_out[31:0], count[40:32], status[42:41]

    deq_scoreboard sb = new();
    bit            calm = 1'b0;
    int            words_sent = 0;

    double_ended_queue_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 4);
    endfunction

    task automatic send_word(op_t op, logic [POS_W-1:0] pos, logic [DIN_W-1:0] din);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {din, pos};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_word(op, pos, din);
        words_sent++;
    endtask

    // Hold the sender back until every owed result has come out
    task automatic wait_until_settled();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Random word shaped by the current bias; positions mostly land inside the deque
    task automatic random_word(bias_t bias);
        op_t         op;
        logic [7:0]  pos;
        logic [31:0] din;
        int          r;
        int          fill;
        r    = $urandom_range(99, 0);
        fill = sb.fill;
        case (bias)
            BIAS_GROW:
                if (r < 40)      op = OP_PUSH_BACK;
                else if (r < 65) op = OP_PUSH_FRONT;
                else if (r < 92) op = OP_INSERT;
                else             op = op_t'($urandom_range(7, 0));
            BIAS_SHRINK:
                if (r < 30)      op = OP_POP_BACK;
                else if (r < 60) op = OP_POP_FRONT;
                else if (r < 88) op = OP_ERASE;
                else             op = op_t'($urandom_range(7, 0));
            default:
                op = op_t'($urandom_range(7, 0));
        endcase
        pos = 8'($urandom_range(255, 0));
        if ($urandom_range(99, 0) < 80)
        begin
            if (op == OP_INSERT)
                pos = 8'($urandom_range((fill > 255) ? 255 : fill, 0));
            else if (fill > 0)
                pos = 8'($urandom_range(fill - 1, 0));
        end
        r = $urandom_range(99, 0);
        if (r < 5)
            din = '0;
        else if (r < 10)
            din = '1;
        else
            din = $urandom();
        send_word(op, pos, din);
    endtask

    // Result side: sample at the edge, then choose ready for the next cycle
    initial
    begin
        int hold;
        hold = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                hold = gap_len();
                m_tready <= (hold == 0);
            end
        end
    end

    // Hang guard
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // Main sequence
    initial
    begin
        bias_t bias;
        int    seg;
        int    seg_len;
        int    n;
        seg = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty deque: every removal and access is refused
        send_word(OP_POP_BACK,   8'd0,   32'h0000_0000);
        send_word(OP_POP_FRONT,  8'd0,   32'h0000_0000);
        send_word(OP_READ,       8'd0,   32'h0000_0000);
        send_word(OP_WRITE,      8'd0,   32'hFFFF_FFFF);
        send_word(OP_ERASE,      8'd0,   32'h0000_0000);
        send_word(OP_INSERT,     8'd1,   32'h1234_5678);
        // insert at the end of an empty deque, the plain pushes, then reads and a write
        send_word(OP_INSERT,     8'd0,   32'hFFFF_FFFF);
        send_word(OP_PUSH_BACK,  8'd255, 32'h0000_0000);
        send_word(OP_PUSH_FRONT, 8'd0,   32'hA5A5_5A5A);
        send_word(OP_READ,       8'd255, 32'h0000_0000);
        send_word(OP_READ,       8'd2,   32'h0000_0000);
        send_word(OP_WRITE,      8'd1,   32'hFFFF_FFFF);
        // insert at count appends, in the middle shifts, past count is refused; then erases, pops and accesses
        send_word(OP_INSERT,     8'd3,   32'h0000_0001);
        send_word(OP_INSERT,     8'd1,   32'h8000_0001);
        send_word(OP_INSERT,     8'd7,   32'h0BAD_F00D);
        send_word(OP_ERASE,      8'd5,   32'h0000_0000);
        send_word(OP_ERASE,      8'd0,   32'h0000_0000);
        send_word(OP_ERASE,      8'd3,   32'h0000_0000);
        send_word(OP_POP_FRONT,  8'd0,   32'h0000_0000);
        send_word(OP_POP_BACK,   8'd0,   32'h0000_0000);
        send_word(OP_READ,       8'd0,   32'h0000_0000);
        send_word(OP_WRITE,      8'd255, 32'hFFFF_FFFF);
        wait_until_settled();

        // random stretches: first fill up to full, then drain past empty
        while (words_sent < WORD_TARGET)
        begin
            if (seg == 0)
            begin
                bias    = BIAS_GROW;
                seg_len = 380;
            end
            else if (seg == 1)
            begin
                bias    = BIAS_SHRINK;
                seg_len = 380;
            end
            else
            begin
                bias    = bias_t'($urandom_range(2, 0));
                seg_len = (bias == BIAS_MIXED) ? $urandom_range(150, 60)
                                               : $urandom_range(360, 120);
            end
            calm = ($urandom_range(3, 0) == 0);
            for (n = 0; n < seg_len && words_sent < WORD_TARGET; n++)
                random_word(bias);
            if ($urandom_range(2, 0) == 0)
                wait_until_settled();
            seg++;
        end

        wait_until_settled();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
